// ===== rtl/cv3_pkg.sv =====
// Shared types and constants for the 3x3 valid-mode convolution stream.
package cv3_pkg;

    // Image side length in pixels; the line stores hold one entry per column.
    localparam int IMAGE_SIZE = 256;
    localparam int ADDR_W     = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;

    localparam int PIX_W    = 8;
    localparam int WGT_W    = 8;
    localparam int PROD_W   = 17;
    localparam int COLSUM_W = 18;
    localparam int OUT_W    = 20;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_BOTTOM = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WEIGHTS_TOP    = 24'h010101;
    localparam logic [CFG_W-1:0] RESET_WEIGHTS_MID    = 24'h000000;
    localparam logic [CFG_W-1:0] RESET_WEIGHTS_BOTTOM = 24'hFFFFFF;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, top to bottom.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } wcol_t;

    // The three weights that apply to one window column.
    typedef struct packed {
        logic signed [WGT_W-1:0] top;
        logic signed [WGT_W-1:0] mid;
        logic signed [WGT_W-1:0] bot;
    } wts_t;

    // One line store entry: the previous row and the row before that.
    typedef struct packed {
        pix_t above1;
        pix_t above2;
    } line_pair_t;

endpackage

// ===== rtl/cv3_line_buf.sv =====
// Line store memory holding the two previous image rows, one entry per column.
module cv3_line_buf (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [cv3_pkg::ADDR_W-1:0] rd_addr,
    output cv3_pkg::line_pair_t        rd_data,
    input  logic                       wr_en,
    input  logic [cv3_pkg::ADDR_W-1:0] wr_addr,
    input  cv3_pkg::line_pair_t        wr_data
);
    import cv3_pkg::*;

    line_pair_t mem_reg [IMAGE_SIZE];
    line_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cv3_cell.sv =====
// One window column cell: holds three pixels, passes them on and forms its column sum.
module cv3_cell (
    input  logic                                   aclk,
    input  logic                                   shift_en,
    input  cv3_pkg::wcol_t                         col_in,
    input  logic                                   sum_en,
    input  cv3_pkg::wts_t                          weights,
    output cv3_pkg::wcol_t                         col_out,
    output logic signed [cv3_pkg::COLSUM_W-1:0]    col_sum
);
    import cv3_pkg::*;

    wcol_t                      col_reg;
    logic signed [COLSUM_W-1:0] sum_reg;
    logic signed [COLSUM_W-1:0] sum_next;
    logic signed [PIX_W:0]      px_top;
    logic signed [PIX_W:0]      px_mid;
    logic signed [PIX_W:0]      px_bot;
    logic signed [PROD_W-1:0]   prod_top;
    logic signed [PROD_W-1:0]   prod_mid;
    logic signed [PROD_W-1:0]   prod_bot;

    always_comb begin
        px_top   = {1'b0, col_reg.top};
        px_mid   = {1'b0, col_reg.mid};
        px_bot   = {1'b0, col_reg.bot};
        prod_top = px_top * weights.top;
        prod_mid = px_mid * weights.mid;
        prod_bot = px_bot * weights.bot;
        sum_next = {prod_top[PROD_W-1], prod_top}
                 + {prod_mid[PROD_W-1], prod_mid}
                 + {prod_bot[PROD_W-1], prod_bot};
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        if (sum_en) begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

// ===== rtl/conv3x3_valid_stream.sv =====
// Top level of the streaming 3x3 valid-mode convolution over a square image.
//
//   Channel   Ports                                          Direction
//   input     s_valid, s_ready, s_pixel                      word in
//   result    m_valid, m_ready, m_filtered, m_out_col,       word out
//             m_out_row, m_frame_last
//   config    cfg_wr_en, cfg_index, cfg_wdata                write only
//
// One pixel word is taken per clock when the result side keeps up; a result
// passes through one register stage each for the line store read, the window
// shift, the column products and the final three-way add, in that order.
// Reset (aresetn low at a clock edge) empties every stage, returns the counters
// to the top left corner and loads the default weights.  A stalled result only
// holds the stages behind it once they are full; empty stages keep taking words.
module conv3x3_valid_stream (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Pixel input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_pixel,
    // Result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [19:0]                 m_filtered,
    output logic [9:0]                         m_out_col,
    output logic [9:0]                         m_out_row,
    output logic                               m_frame_last,
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cv3_pkg::CFG_W-1:0]          cfg_wdata
);
    import cv3_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(IMAGE_SIZE - 1);
    localparam logic [ADDR_W-1:0] FIRST_FULL = ADDR_W'(2);

    // Weight registers.
    logic [CFG_W-1:0] w_top_reg;
    logic [CFG_W-1:0] w_mid_reg;
    logic [CFG_W-1:0] w_bot_reg;

    // Raster position of the next pixel to be accepted.
    logic [ADDR_W-1:0] col_cnt_reg;
    logic [ADDR_W-1:0] row_cnt_reg;
    logic [ADDR_W-1:0] col_cnt_next;
    logic [ADDR_W-1:0] row_cnt_next;

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
    logic in_fire;

    // Stage A: accepted pixel and its position, line store read in flight.
    logic              a_valid_reg;
    pix_t              a_px_reg;
    logic [ADDR_W-1:0] a_col_reg;
    logic [ADDR_W-1:0] a_row_reg;

    // Stage B: window held in the cells, position of its left/top edge.
    logic             b_valid_reg;
    logic             b_emit_reg;
    logic [POS_W-1:0] b_col_reg;
    logic [POS_W-1:0] b_row_reg;
    logic             b_last_reg;

    // Stage C: column sums held in the cells.
    logic             c_valid_reg;
    logic [POS_W-1:0] c_col_reg;
    logic [POS_W-1:0] c_row_reg;
    logic             c_last_reg;

    // Stage D: output register.
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] filtered_reg;
    logic [POS_W-1:0]        out_col_reg;
    logic [POS_W-1:0]        out_row_reg;
    logic                    frame_last_reg;
    logic signed [OUT_W-1:0] filtered_next;

    line_pair_t                 lb_rd_data;
    line_pair_t                 lb_wr_data;
    wcol_t                      new_col;
    wcol_t                      cell_in   [3];
    wcol_t                      cell_out  [3];
    wts_t                       cell_wts  [3];
    logic signed [COLSUM_W-1:0] cell_sum  [3];

    // Handshake and stage movement.
    always_comb begin
        en_d    = !m_valid_reg || m_ready;
        en_c    = !c_valid_reg || en_d;
        en_b    = !b_valid_reg || en_c;
        en_a    = !a_valid_reg || en_b;
        in_fire = s_valid && en_a;
    end

    assign s_ready = en_a;

    // Configuration writes; indexes beyond the three registers are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_top_reg <= RESET_WEIGHTS_TOP;
            w_mid_reg <= RESET_WEIGHTS_MID;
            w_bot_reg <= RESET_WEIGHTS_BOTTOM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WEIGHTS_TOP:    w_top_reg <= cfg_wdata;
                CFG_WEIGHTS_MID:    w_mid_reg <= cfg_wdata;
                CFG_WEIGHTS_BOTTOM: w_bot_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Raster counters wrap at the end of each row and of the frame.
    always_comb begin
        if (col_cnt_reg == LAST_POS) begin
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg == LAST_POS) ? '0 : row_cnt_reg + 1'b1;
        end else begin
            col_cnt_next = col_cnt_reg + 1'b1;
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (in_fire) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Stage A.  The line store entry for this column is read as the pixel is
    // taken and rewritten while the pixel sits here; the next access to the
    // same column is a whole row later, so the write has always landed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_px_reg  <= s_pixel;
            a_col_reg <= col_cnt_reg;
            a_row_reg <= row_cnt_reg;
        end
    end

    assign lb_wr_data.above1 = a_px_reg;
    assign lb_wr_data.above2 = lb_rd_data.above1;

    cv3_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (in_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (lb_rd_data),
        .wr_en   (a_valid_reg),
        .wr_addr (a_col_reg),
        .wr_data (lb_wr_data)
    );

    // Stage B.  The window shifts one column to the left for every pixel,
    // whether or not that pixel completes a full window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b && a_valid_reg) begin
            b_emit_reg <= (a_row_reg >= FIRST_FULL) && (a_col_reg >= FIRST_FULL);
            b_col_reg  <= POS_W'(a_col_reg - FIRST_FULL);
            b_row_reg  <= POS_W'(a_row_reg - FIRST_FULL);
            b_last_reg <= (a_row_reg == LAST_POS) && (a_col_reg == LAST_POS);
        end
    end

    assign new_col.top = lb_rd_data.above2;
    assign new_col.mid = lb_rd_data.above1;
    assign new_col.bot = a_px_reg;

    // The chain of window cells: the newest column enters the rightmost cell
    // and each cell hands its column to its left neighbour.
    for (genvar c = 0; c < 3; c++) begin : g_cell
        if (c == 2) begin : g_entry
            assign cell_in[c] = new_col;
        end else begin : g_link
            assign cell_in[c] = cell_out[c+1];
        end

        assign cell_wts[c].top = w_top_reg[WGT_W*c +: WGT_W];
        assign cell_wts[c].mid = w_mid_reg[WGT_W*c +: WGT_W];
        assign cell_wts[c].bot = w_bot_reg[WGT_W*c +: WGT_W];

        cv3_cell u_cell (
            .aclk     (aclk),
            .shift_en (en_b && a_valid_reg),
            .col_in   (cell_in[c]),
            .sum_en   (en_c && b_valid_reg),
            .weights  (cell_wts[c]),
            .col_out  (cell_out[c]),
            .col_sum  (cell_sum[c])
        );
    end

    // Stage C.  Only windows that are full carry on as results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c && b_valid_reg) begin
            c_col_reg  <= b_col_reg;
            c_row_reg  <= b_row_reg;
            c_last_reg <= b_last_reg;
        end
    end

    // Stage D: the three column sums are added into the output register.
    assign filtered_next = OUT_W'(cell_sum[0]) + OUT_W'(cell_sum[1]) + OUT_W'(cell_sum[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_d) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d && c_valid_reg) begin
            filtered_reg   <= filtered_next;
            out_col_reg    <= c_col_reg;
            out_row_reg    <= c_row_reg;
            frame_last_reg <= c_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = filtered_reg;
    assign m_out_col    = out_col_reg;
    assign m_out_row    = out_row_reg;
    assign m_frame_last = frame_last_reg;

endmodule

// ===== tb/conv3x3_valid_stream_test.sv =====
// Self-checking testbench for the streaming 3x3 valid-mode convolution block.
module conv3x3_valid_stream_test;
    import cv3_pkg::*;

    // Write to the fourth register index; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 2'd3;

    // Cycles to let pass once the last expected word has come back.  The block
    // is four register stages deep, so a pixel word that completes no window
    // may still be moving through it.
    localparam int DRAIN_CYCLES   = 8;
    // Long hold-off on the result side, long enough to fill every stage.
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 3;
    localparam int PHASE_ITEMS    = 110;
    // A flat block long enough to fill two line stores and a few windows.
    localparam int FLAT_ITEMS     = 2 * IMAGE_SIZE + 16;

    typedef enum logic [1:0] {
        FILL_LEVEL,
        FILL_RANDOM,
        FILL_EXTREMES
    } fill_e;

    // One directed row: the weights to load, how its pixels are drawn and how
    // many are sent.  When pinned is set, every result whose window holds nine
    // copies of the same level carries the sum typed in here.
    typedef struct packed {
        bit                       reload;
        logic [CFG_W-1:0]         w_top;
        logic [CFG_W-1:0]         w_mid;
        logic [CFG_W-1:0]         w_bot;
        fill_e                    fill;
        logic [PIX_W-1:0]         level;
        int unsigned              count;
        bit                       pinned;
        logic signed [OUT_W-1:0]  sum;
    } dir_case_t;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic                    last;
    } conv_result_t;

    dir_case_t directed_cases [0:5] = '{
        // Default weights straight after reset: a flat image sums to zero.
        '{1'b0, RESET_WEIGHTS_TOP, RESET_WEIGHTS_MID, RESET_WEIGHTS_BOTTOM,
          FILL_LEVEL, 8'd200, FLAT_ITEMS, 1'b1, 20'sd0},
        // Most negative weights on the brightest pixels: the bottom of the range.
        '{1'b1, 24'h808080, 24'h808080, 24'h808080,
          FILL_LEVEL, 8'd255, FLAT_ITEMS, 1'b1, -20'sd293760},
        // Most positive weights on the same bright image.
        '{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F,
          FILL_LEVEL, 8'd255, 32, 1'b1, 20'sd291465},
        // Opposite extremes on top and bottom rows nearly cancel.
        '{1'b1, 24'h7F7F7F, 24'h000000, 24'h808080,
          FILL_LEVEL, 8'd255, 32, 1'b1, -20'sd765},
        // Nine distinct weights on noise: catches any mix-up of row or column.
        '{1'b1, 24'h030201, 24'h060504, 24'hF9F8F7,
          FILL_RANDOM, 8'd0, 128, 1'b0, 20'sd0},
        // Back to the default weights, pixels only at the two extremes.
        '{1'b1, RESET_WEIGHTS_TOP, RESET_WEIGHTS_MID, RESET_WEIGHTS_BOTTOM,
          FILL_EXTREMES, 8'd0, 128, 1'b0, 20'sd0}
    };

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [7:0]              s_pixel;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [19:0]      m_filtered;
    logic [9:0]              m_out_col;
    logic [9:0]              m_out_row;
    logic                    m_frame_last;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_wdata;

    conv3x3_valid_stream dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_frame_last (m_frame_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // Predictor state: a copy of the block's line stores, window, scan position
    // and weights.  The line stores start at zero, which never reaches a result.
    pix_t             line_prev1 [IMAGE_SIZE] = '{default: '0};
    pix_t             line_prev2 [IMAGE_SIZE] = '{default: '0};
    pix_t             win [3][3] = '{default: '{default: '0}};
    int unsigned      pos_col = 0;
    int unsigned      pos_row = 0;
    logic [CFG_W-1:0] wt_top = RESET_WEIGHTS_TOP;
    logic [CFG_W-1:0] wt_mid = RESET_WEIGHTS_MID;
    logic [CFG_W-1:0] wt_bot = RESET_WEIGHTS_BOTTOM;

    // Results still owed by the block, oldest first.
    conv_result_t expected_sums [$];

    int  errors = 0;
    bit  src_steady = 1'b0;
    bit  hold_results = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Takes one pixel word into the window and returns 1 with the result when
    // the window covers a full 3x3 neighbourhood.
    function automatic bit advance_window(input pix_t px, output conv_result_t res);
        int unsigned      col;
        int unsigned      row;
        pix_t             up2;
        pix_t             up1;
        logic [CFG_W-1:0] packs [3];
        int               total;
        int               pv;
        int               wv;
        col = pos_col;
        row = pos_row;
        up2 = line_prev2[col];
        up1 = line_prev1[col];
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = px;
        line_prev2[col] = up1;
        line_prev1[col] = px;

        advance_window = 1'b0;
        res.filtered = '0;
        res.col = '0;
        res.row = '0;
        res.last = 1'b0;
        if (row >= 2 && col >= 2) begin
            packs[0] = wt_top;
            packs[1] = wt_mid;
            packs[2] = wt_bot;
            total = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pv = int'(win[r][c]);
                    wv = int'($signed(packs[r][8*c +: 8]));
                    total += pv * wv;
                end
            end
            res.filtered = total[OUT_W-1:0];
            res.col = POS_W'(col - 2);
            res.row = POS_W'(row - 2);
            res.last = (row == IMAGE_SIZE - 1) && (col == IMAGE_SIZE - 1);
            advance_window = 1'b1;
        end

        // Raster scan: wrap the column at the end of a row, the row at the end
        // of a frame.
        if (col == IMAGE_SIZE - 1) begin
            pos_col = 0;
            if (row == IMAGE_SIZE - 1) begin
                pos_row = 0;
            end else begin
                pos_row = row + 1;
            end
        end else begin
            pos_col = col + 1;
        end
    endfunction

    // True when all nine window pixels equal the given level.
    function automatic bit window_flat(input pix_t level);
        window_flat = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (win[r][c] != level)
                    window_flat = 1'b0;
            end
        end
    endfunction

    function automatic pix_t pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Each weight byte leans towards the extremes and the values around zero.
    function automatic logic [CFG_W-1:0] pick_weights();
        logic [CFG_W-1:0] w;
        for (int b = 0; b < 3; b++) begin
            case ($urandom_range(0, 4))
                0: w[8*b +: 8] = 8'h80;
                1: w[8*b +: 8] = 8'h7F;
                2: w[8*b +: 8] = 8'h00;
                3: w[8*b +: 8] = 8'hFF;
                default: w[8*b +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return w;
    endfunction

    // Offers one pixel word after a random gap and, once it is taken, records
    // the result it causes.  The valid line is only dropped when a gap follows,
    // so back-to-back words keep it high.
    task automatic send_pixel(input pix_t px, input bit pinned,
                              input logic signed [OUT_W-1:0] pinned_sum);
        int           gap;
        conv_result_t res;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0)
            src_steady = !src_steady;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        if (advance_window(px, res)) begin
            if (pinned && window_flat(px))
                res.filtered = pinned_sum;
            expected_sums.push_back(res);
        end
    endtask

    // Stops the input and waits until the block has nothing left in flight.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Loads all three weight rows, with a stray write to the unused index in
    // between that must change nothing.
    task automatic load_weights(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] mid,
                                input logic [CFG_W-1:0] bot);
        write_reg(CFG_WEIGHTS_TOP, top);
        write_reg(CFG_INDEX_SPARE, CFG_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_WEIGHTS_MID, mid);
        write_reg(CFG_WEIGHTS_BOTTOM, bot);
        cfg_wr_en <= 1'b0;
        wt_top = top;
        wt_mid = mid;
        wt_bot = bot;
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result side: stalls at random, now and then for a long stretch, and
    // checks every word it takes against the oldest expectation.
    initial begin
        int           stall;
        bit           sink_steady;
        conv_result_t want;
        sink_steady = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_results) begin
                stall = HOLD_CYCLES;
                hold_results = 1'b0;
            end else begin
                stall = sink_steady ? 0 : $urandom_range(0, 7);
            end
            if ($urandom_range(0, 63) == 0)
                sink_steady = !sink_steady;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d at (%0d,%0d)",
                         $time, m_filtered, m_out_row, m_out_col);
            end else begin
                want = expected_sums.pop_front();
                compare_field("filtered", int'(want.filtered), int'(m_filtered));
                compare_field("out_col", int'(want.col), int'(m_out_col));
                compare_field("out_row", int'(want.row), int'(m_out_row));
                compare_field("frame_last", int'(want.last), int'(m_frame_last));
            end
        end
    end

    // Stimulus: the directed table, then random phases under fresh weights.
    initial begin
        pix_t px;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_pixel   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_WEIGHTS_TOP;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[i]) begin
            drain_results();
            if (directed_cases[i].reload)
                load_weights(directed_cases[i].w_top, directed_cases[i].w_mid,
                             directed_cases[i].w_bot);
            for (int k = 0; k < directed_cases[i].count; k++) begin
                case (directed_cases[i].fill)
                    FILL_LEVEL:    px = directed_cases[i].level;
                    FILL_EXTREMES: px = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    default:       px = pix_t'($urandom_range(0, 255));
                endcase
                send_pixel(px, directed_cases[i].pinned, directed_cases[i].sum);
            end
        end

        // Each phase starts from an empty pipeline, so the input also pauses
        // until every result is home.  The second phase opens with the long
        // result-side hold-off while words keep being offered.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            load_weights(pick_weights(), pick_weights(), pick_weights());
            if (ph == 1)
                hold_results = 1'b1;
            repeat (PHASE_ITEMS) send_pixel(pick_pixel(), 1'b0, '0);
        end

        drain_results();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #(64'd4_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cv3_pkg.sv
rtl/cv3_line_buf.sv
rtl/cv3_cell.sv
rtl/conv3x3_valid_stream.sv
tb/conv3x3_valid_stream_test.sv
